/* rtl/core/mkrs_pkg.sv */
// Shared types and constants for the multi-key record sorter.
// Used by the controller, datapath and top level; no dependencies.
`default_nettype none

package mkrs_pkg;

  // Sort key codes held in the configuration register.
  localparam logic [1:0] KEY_TICKET = 2'd0;
  localparam logic [1:0] KEY_DATE   = 2'd1;
  localparam logic [1:0] KEY_WEIGHT = 2'd2;
  localparam logic [1:0] KEY_NONE   = 2'd3;

  localparam int unsigned RecBits  = 63;
  localparam int unsigned DataBits = 64;

  // First member is the MSB, so ticket_code lands in the lowest bits.
  typedef struct packed {
    logic [7:0]  record_tag;
    logic [9:0]  luggage_weight;
    logic [7:0]  luggage_count;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [15:0] ticket_code;
  } rec_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_INIT,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WR2,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic sort_init;
    logic rd_pair;
    logic wr_a;
    logic wr_b;
    logic advance;
    logic emit_init;
    logic rd_emit;
    logic out_load;
    logic emit_next;
    logic batch_clear;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic sort_skip;
    logic swap;
    logic pair_last;
    logic out_taken;
    logic emit_last;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/mkrs_ram.sv */
// Generic simple RAM: one write port, two read ports, registered reads.
// No dependencies.
`default_nettype none

module mkrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output      logic [WIDTH-1:0]         rdata_a_o,
  output      logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mkrs_ctrl.sv */
// Sequencer for load, sort and emit phases of the record sorter.
// Depends on mkrs_pkg (state_e, cmd_t, sts_t).
`default_nettype none

module mkrs_ctrl import mkrs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire sts_t sts_i,
  output      cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (sts_i.in_valid && sts_i.in_last) state_d = ST_SORT_INIT;
      end
      ST_SORT_INIT: begin
        state_d = sts_i.sort_skip ? ST_EMIT_RD : ST_SORT_RD;
      end
      ST_SORT_RD: state_d = ST_SORT_CMP;
      ST_SORT_CMP: begin
        if (sts_i.swap) state_d = ST_SORT_WR2;
        else if (sts_i.pair_last) state_d = ST_EMIT_RD;
        else state_d = ST_SORT_RD;
      end
      ST_SORT_WR2: begin
        state_d = sts_i.pair_last ? ST_EMIT_RD : ST_SORT_RD;
      end
      ST_EMIT_RD: state_d = ST_EMIT_LD;
      ST_EMIT_LD: state_d = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (sts_i.out_taken) state_d = sts_i.emit_last ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_LOAD: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load     = sts_i.in_valid;
      end
      ST_SORT_INIT: cmd_o.sort_init = 1'b1;
      ST_SORT_RD:   cmd_o.rd_pair   = 1'b1;
      ST_SORT_CMP: begin
        // on a swap the pair index moves only after the second write
        if (sts_i.swap) cmd_o.wr_a = 1'b1;
        else if (sts_i.pair_last) cmd_o.emit_init = 1'b1;
        else cmd_o.advance = 1'b1;
      end
      ST_SORT_WR2: begin
        cmd_o.wr_b = 1'b1;
        if (sts_i.pair_last) cmd_o.emit_init = 1'b1;
        else cmd_o.advance = 1'b1;
      end
      ST_EMIT_RD: cmd_o.rd_emit  = 1'b1;
      ST_EMIT_LD: cmd_o.out_load = 1'b1;
      ST_EMIT_WAIT: begin
        if (sts_i.out_taken) begin
          if (sts_i.emit_last) cmd_o.batch_clear = 1'b1;
          else cmd_o.emit_next = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/mkrs_datapath.sv */
// Record store, pair indexes, key compare and output register of the sorter.
// Depends on mkrs_pkg and mkrs_ram.
`default_nettype none

module mkrs_datapath import mkrs_pkg::*; #(
  parameter int unsigned RECORDS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output      sts_t                sts_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_wdata_i,
  input  wire logic                in_valid_i,
  input  wire logic [DataBits-1:0] in_data_i,
  input  wire logic                in_last_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [DataBits-1:0] out_data_o,
  output      logic                out_ovf_o,
  output      logic                out_last_o
);

  localparam int unsigned AW  = $clog2(RECORDS);
  localparam int unsigned CW  = $clog2(RECORDS + 1);
  localparam int unsigned CW1 = CW + 1;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [1:0]    key_q;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic          out_valid_q, out_valid_d;
  logic          out_last_q;
  logic          out_ovf_q;
  rec_t          out_rec_q;

  rec_t          in_rec, rec_a, rec_b, wdata;
  logic          full, bubble, we, inner_end, pair_last;
  logic [AW-1:0] waddr;
  logic [CW-1:0] a_idx, b_idx;
  logic [CW1-1:0] i_ext, j_ext, n_ext;

  assign in_rec = rec_t'(in_data_i[RecBits-1:0]);
  assign full   = (count_q == CW'(RECORDS));
  assign bubble = (key_q == KEY_TICKET);

  assign a_idx = bubble ? j_q : i_q;
  assign b_idx = bubble ? (j_q + CW'(1)) : j_q;

  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = in_rec;
    if (cmd_i.load && !full) begin
      we = 1'b1;
    end else if (cmd_i.wr_a) begin
      we    = 1'b1;
      waddr = a_idx[AW-1:0];
      wdata = rec_b;
    end else if (cmd_i.wr_b) begin
      we    = 1'b1;
      waddr = b_idx[AW-1:0];
      wdata = rec_a;
    end
  end

  mkrs_ram #(
    .WIDTH (RecBits),
    .DEPTH (RECORDS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (cmd_i.rd_pair || cmd_i.rd_emit),
    .raddr_a_i (cmd_i.rd_emit ? i_q[AW-1:0] : a_idx[AW-1:0]),
    .raddr_b_i (b_idx[AW-1:0]),
    .rdata_a_o (rec_a),
    .rdata_b_o (rec_b)
  );

  assign i_ext = {1'b0, i_q};
  assign j_ext = {1'b0, j_q};
  assign n_ext = {1'b0, count_q};

  // bubble: inner pass runs while j+1 < n-i; exchange: while j < n
  assign inner_end = bubble ? ((j_ext + i_ext + CW1'(2)) >= n_ext)
                            : ((j_ext + CW1'(1)) >= n_ext);
  assign pair_last = inner_end && ((i_ext + CW1'(2)) >= n_ext);

  always_comb begin
    sts_o           = '0;
    sts_o.in_valid  = in_valid_i;
    sts_o.in_last   = in_last_i;
    sts_o.sort_skip = (count_q < CW'(2)) || (key_q == KEY_NONE);
    sts_o.pair_last = pair_last;
    sts_o.out_taken = out_valid_q && out_ready_i;
    sts_o.emit_last = ((i_ext + CW1'(1)) == n_ext);
    // swap when the later slot orders before the earlier one
    case (key_q)
      KEY_TICKET: sts_o.swap = rec_b.ticket_code < rec_a.ticket_code;
      KEY_DATE:   sts_o.swap = {rec_b.year, rec_b.month, rec_b.day}
                             < {rec_a.year, rec_a.month, rec_a.day};
      KEY_WEIGHT: sts_o.swap = {rec_b.luggage_weight, rec_b.luggage_count}
                             < {rec_a.luggage_weight, rec_a.luggage_count};
      default:    sts_o.swap = 1'b0;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      if (full) ovf_d = 1'b1;
      else count_d = count_q + CW'(1);
    end
    if (cmd_i.batch_clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
    if (cmd_i.sort_init) begin
      i_d = '0;
      j_d = bubble ? '0 : CW'(1);
    end
    if (cmd_i.advance) begin
      if (inner_end) begin
        i_d = i_q + CW'(1);
        j_d = bubble ? '0 : (i_q + CW'(2));
      end else begin
        j_d = j_q + CW'(1);
      end
    end
    if (cmd_i.emit_init) i_d = '0;
    if (cmd_i.emit_next) i_d = i_q + CW'(1);
    if (cmd_i.out_load) out_valid_d = 1'b1;
    else if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      key_q       <= KEY_TICKET;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) key_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_rec_q  <= rec_a;
      out_last_q <= sts_o.emit_last;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {1'b0, out_rec_q};
  assign out_ovf_o   = out_ovf_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

/* rtl/core/multi_key_record_sorter_top.sv */
// Top level of the multi-key record sorter: sequencer plus datapath.
// Depends on mkrs_pkg, mkrs_ctrl, mkrs_datapath, mkrs_ram.
//
//   Channel   Dir   Handshake              Payload
//   s_axis    in    tvalid/tready          tdata record, tlast ends batch
//   m_axis    out   tvalid/tready          tdata record, tuser overflow, tlast
//   cfg       in    we only                2-bit sort key
//
// Load accepts one record per cycle. After tlast and a setup step the sort
// runs n(n-1)/2 compares, none for KEY_NONE or n < 2, over the store's two
// read ports (pair read, compare, second write on swap). Each result takes
// RAM read, output register load and handshake, plus any m_axis stall.
// Input is held off from tlast until the final result is taken.
// Reset clears control state only; the store needs no clearing pass.
`default_nettype none

module multi_key_record_sorter_top import mkrs_pkg::*; #(
  parameter int unsigned RECORDS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_wdata_i,
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  // ticket_code[15:0] year[27:16] month[31:28] day[36:32]
  // luggage_count[44:37] luggage_weight[54:45] record_tag[62:55] pad[63]
  input  wire logic [DataBits-1:0] s_axis_tdata_i,
  input  wire logic                s_axis_tlast_i,
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // out_ticket_code[15:0] out_year[27:16] out_month[31:28] out_day[36:32]
  // out_luggage_count[44:37] out_luggage_weight[54:45] out_record_tag[62:55]
  output      logic [DataBits-1:0] m_axis_tdata_o,
  // overflow[0]
  output      logic                m_axis_tuser_o,
  output      logic                m_axis_tlast_o
);

  cmd_t cmd;
  sts_t sts;

  mkrs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  mkrs_datapath #(
    .RECORDS (RECORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_data_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_ovf_o   (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  assign s_axis_tready_o = cmd.in_ready;

`ifndef SYNTH
  // loading and emitting never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a result is pending");

  // taking the final result reopens the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("input not reopened after final result");

  // a swap write always follows a pair read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_a |-> $past(cmd.rd_pair))
    else $error("swap write without preceding pair read");
`endif

endmodule

`default_nettype wire

/* test/multi_key_record_sorter_top_tb.sv */
// Self-checking bench for multi_key_record_sorter_top: loads record batches
// under each sort key and checks the sorted output stream against a local model.
// Depends on mkrs_pkg and the sorter RTL only.
`timescale 1ns / 100ps

module multi_key_record_sorter_top_tb;
  import mkrs_pkg::*;

  localparam int unsigned RECORDS    = 16;
  localparam int unsigned ITEMS      = 180;
  localparam int unsigned TAIL_START = 150;
  localparam int unsigned SETTLE     = 10;
  localparam int unsigned LIMIT      = 400000;

  typedef struct {
    rec_t rec;
    bit   overflow;
    bit   last;
  } sorted_rec_t;

  class sorter_scoreboard;
    rec_t          batch[RECORDS];
    int unsigned   held;
    bit            dropped;
    logic [1:0]    key;
    sorted_rec_t   sorted_due[$];
    int unsigned   errors;

    function new();
      held    = 0;
      dropped = 0;
      key     = KEY_TICKET;
      errors  = 0;
    endfunction

    function void set_key(logic [1:0] k);
      key = k;
    endfunction

    function int unsigned pending();
      return sorted_due.size();
    endfunction

    function bit earlier_date(rec_t a, rec_t b);
      if (a.year != b.year) return a.year < b.year;
      if (a.month != b.month) return a.month < b.month;
      return a.day < b.day;
    endfunction

    function bit lighter(rec_t a, rec_t b);
      if (a.luggage_weight != b.luggage_weight) return a.luggage_weight < b.luggage_weight;
      return a.luggage_count < b.luggage_count;
    endfunction

    // Same pass order as the hardware so ties land identically.
    function void sort_batch();
      rec_t t;
      bit   sw;
      if (held < 2) return;
      if (key == KEY_TICKET) begin
        for (int i = 0; i + 1 < held; i++)
          for (int j = 0; j + 1 < held - i; j++)
            if (batch[j].ticket_code > batch[j + 1].ticket_code) begin
              t = batch[j];
              batch[j] = batch[j + 1];
              batch[j + 1] = t;
            end
      end else if (key == KEY_DATE || key == KEY_WEIGHT) begin
        for (int i = 0; i + 1 < held; i++)
          for (int j = i + 1; j < held; j++) begin
            sw = (key == KEY_DATE) ? earlier_date(batch[j], batch[i])
                                   : lighter(batch[j], batch[i]);
            if (sw) begin
              t = batch[i];
              batch[i] = batch[j];
              batch[j] = t;
            end
          end
      end
    endfunction

    function void note_record(rec_t r, bit last);
      sorted_rec_t s;
      if (held < RECORDS) begin
        batch[held] = r;
        held++;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      sort_batch();
      for (int k = 0; k < held; k++) begin
        s.rec      = batch[k];
        s.overflow = dropped;
        s.last     = (k + 1 == held);
        sorted_due.push_back(s);
      end
      held    = 0;
      dropped = 0;
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      $display("%0t: mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task compare_field(string what, logic [15:0] got, logic [15:0] want);
      if (got !== want) report(what, got, want);
    endtask

    task check_sorted(rec_t r, logic overflow, logic last);
      sorted_rec_t s;
      if (sorted_due.size() == 0) begin
        report("result with nothing pending, ticket", r.ticket_code, 16'd0);
        return;
      end
      s = sorted_due.pop_front();
      compare_field("ticket_code", r.ticket_code, s.rec.ticket_code);
      compare_field("year", 16'(r.year), 16'(s.rec.year));
      compare_field("month", 16'(r.month), 16'(s.rec.month));
      compare_field("day", 16'(r.day), 16'(s.rec.day));
      compare_field("luggage_count", 16'(r.luggage_count), 16'(s.rec.luggage_count));
      compare_field("luggage_weight", 16'(r.luggage_weight), 16'(s.rec.luggage_weight));
      compare_field("record_tag", 16'(r.record_tag), 16'(s.rec.record_tag));
      compare_field("overflow", 16'(overflow), 16'(s.overflow));
      compare_field("last", 16'(last), 16'(s.last));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_wdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [DataBits-1:0] s_axis_tdata_i = '0;
  logic                s_axis_tlast_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [DataBits-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                m_axis_tlast_o;

  sorter_scoreboard sb = new();
  int unsigned      items_sent = 0;
  int unsigned      cycles = 0;
  bit               quiet_tail = 0;

  multi_key_record_sorter_top #(.RECORDS(RECORDS)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_sorted(rec_t'(m_axis_tdata_o[RecBits-1:0]), m_axis_tuser_o, m_axis_tlast_o);
  end

  // Output side: ready, with occasional stalls outside the quiet tail.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  function automatic rec_t make_rec(logic [15:0] ticket, logic [11:0] year, logic [3:0] month,
                                    logic [4:0] day, logic [7:0] cnt, logic [9:0] weight,
                                    logic [7:0] tag);
    rec_t r;
    r.ticket_code    = ticket;
    r.year           = year;
    r.month          = month;
    r.day            = day;
    r.luggage_count  = cnt;
    r.luggage_weight = weight;
    r.record_tag     = tag;
    return r;
  endfunction

  // crowded batches draw keys from tiny ranges so ties are common
  function automatic rec_t random_record(bit crowded);
    rec_t r;
    if (crowded)
      r = make_rec(16'($urandom_range(0, 3)), 12'($urandom_range(2000, 2001)),
                   4'($urandom_range(1, 2)), 5'($urandom_range(1, 2)),
                   8'($urandom_range(0, 1)), 10'($urandom_range(20, 21)), 8'($urandom));
    else
      r = make_rec(16'($urandom), 12'($urandom), 4'($urandom), 5'($urandom),
                   8'($urandom), 10'($urandom), 8'($urandom));
    return r;
  endfunction

  task send_record(rec_t r, bit last, bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, r};
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_record(r, last);
    items_sent++;
    // the block is busy sorting or emitting after the last request, so this edge costs nothing
    if (last) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Wait until all sorted records are out, then let the block settle.
  task drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task write_key(logic [1:0] k);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    sb.set_key(k);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned size;
    int unsigned round;
    bit          crowded;
    bit          bursty;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ticket key: extremes and a tie that must keep load order
    write_key(KEY_TICKET);
    send_record(make_rec(16'hFFFF, 12'hFFF, 4'hF, 5'h1F, 8'hFF, 10'h3FF, 8'hFF), 0, 1);
    send_record(make_rec(16'h1234, 12'd2020, 4'd6, 5'd15, 8'd2, 10'd30, 8'h01), 0, 1);
    send_record(make_rec(16'h0000, 12'h000, 4'h0, 5'h00, 8'h00, 10'h000, 8'h00), 0, 1);
    send_record(make_rec(16'h1234, 12'd2019, 4'd1, 5'd2, 8'd3, 10'd40, 8'h02), 1, 1);
    // a batch of one
    send_record(make_rec(16'hBEEF, 12'd1999, 4'd12, 5'd31, 8'd1, 10'd5, 8'h33), 1, 1);
    drain();

    // date key: year, month and day decide in turn; one month out of range
    write_key(KEY_DATE);
    send_record(make_rec(16'd1, 12'd2024, 4'd15, 5'd31, 8'd1, 10'd10, 8'h10), 0, 1);
    send_record(make_rec(16'd2, 12'd2024, 4'd3, 5'd7, 8'd2, 10'd20, 8'h11), 0, 1);
    send_record(make_rec(16'd3, 12'd2024, 4'd3, 5'd2, 8'd3, 10'd30, 8'h12), 0, 1);
    send_record(make_rec(16'd4, 12'd2023, 4'd3, 5'd7, 8'd4, 10'd40, 8'h13), 0, 1);
    send_record(make_rec(16'd5, 12'd2024, 4'd3, 5'd7, 8'd5, 10'd50, 8'h14), 1, 1);
    drain();

    // weight key: weight first, count breaks ties, one full tie
    write_key(KEY_WEIGHT);
    send_record(make_rec(16'd9, 12'd1, 4'd1, 5'd1, 8'd7, 10'd300, 8'h20), 0, 1);
    send_record(make_rec(16'd8, 12'd1, 4'd1, 5'd1, 8'd2, 10'd300, 8'h21), 0, 1);
    send_record(make_rec(16'd7, 12'd1, 4'd1, 5'd1, 8'd2, 10'd300, 8'h22), 0, 1);
    send_record(make_rec(16'd6, 12'd1, 4'd1, 5'd1, 8'd9, 10'd12, 8'h23), 1, 1);
    drain();

    // unused key: load order
    write_key(KEY_NONE);
    send_record(make_rec(16'd30, 12'd3, 4'd3, 5'd3, 8'd3, 10'd3, 8'h30), 0, 1);
    send_record(make_rec(16'd10, 12'd1, 4'd1, 5'd1, 8'd1, 10'd1, 8'h31), 0, 1);
    send_record(make_rec(16'd20, 12'd2, 4'd2, 5'd2, 8'd2, 10'd2, 8'h32), 1, 1);

    round = 0;
    while (items_sent < ITEMS) begin
      if (items_sent >= TAIL_START) quiet_tail = 1;
      if (round == 0)
        size = RECORDS + 1;   // last record itself is dropped
      else if (round == 1)
        size = RECORDS;       // exactly full, no overflow
      else if ($urandom_range(0, 7) == 0)
        size = $urandom_range(RECORDS + 1, RECORDS + 4);
      else
        size = $urandom_range(1, RECORDS);
      if (round < 2 || $urandom_range(0, 2) == 0) begin
        drain();
        write_key(round == 0 ? KEY_WEIGHT : 2'($urandom_range(0, 3)));
      end
      crowded = $urandom_range(0, 1);
      bursty  = !quiet_tail && $urandom_range(0, 3) != 0;
      for (int k = 0; k < size; k++)
        send_record(random_record(crowded), k == size - 1, bursty);
      round++;
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
